/* src/rek_pkg.sv */
// shared widths, constants and types for the rolling excess kurtosis block
package rek_pkg;

   localparam int SAMPLE_W       = 14;
   localparam int PERIOD_W       = 9;
   localparam int KURT_W         = 32;
   localparam int PERIOD_MIN     = 4;
   localparam int PERIOD_MAX_DEF = 256;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(5);

   // running sum widths, sized for the largest window
   localparam int S1_W = 23;
   localparam int S2_W = 36;
   localparam int S3_W = 49;
   localparam int S4_W = 62;

   // shared multiplier geometry
   localparam int WIDE_W  = 128;
   localparam int OPB_W   = 64;
   localparam int DIGIT_W = 8;

   // input queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       new_series;
   } item_type;

endpackage

/* src/rek_if.sv */
// handshake channels of the rolling excess kurtosis block
interface rek_req_if import rek_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       new_series;
   modport source (output valid, sample, new_series, input ready);
   modport sink   (input valid, sample, new_series, output ready);
endinterface

interface rek_rsp_if import rek_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [KURT_W-1:0] excess_kurtosis;
   logic                     undefined;
   modport source (output valid, excess_kurtosis, undefined, input ready);
   modport sink   (input valid, excess_kurtosis, undefined, output ready);
endinterface

interface rek_csr_if import rek_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PERIOD_W-1:0] period;
   modport source (output valid, period, input ready);
   modport sink   (input valid, period, output ready);
endinterface

/* src/rolling_excess_kurtosis.sv */
// rolling excess kurtosis (g2) top level: front queue plus back sequencer
// sequence: while the window fills a beat gives no result; once full, a zero-spread
//   window ends early as undefined, else the shared 128x8 multiplier forms twelve
//   products one byte of b at a time, then a 32-step divider runs
// throughput: one beat at a time in the back; the front queue holds two beats
// reset: synchronous, clears window, sums and queue, period back to 5
module rolling_excess_kurtosis import rek_pkg::*; #(
   parameter int PERIOD_MAX = PERIOD_MAX_DEF
) (
   input  logic      clock,
   input  logic      reset,
   rek_req_if.sink   req_bus,
   rek_rsp_if.source rsp_bus,
   rek_csr_if.sink   csr_bus
);

   // item handoff from the intake queue to the compute side
   logic     item_valid;
   logic     item_pop;
   item_type item;

   // front: takes sample beats and buffers them so the source is not held
   // while the back works through a long kurtosis evaluation
   rek_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   // back: window store, exact moment sums, product sequence for a and b,
   // long division into q16.16 with rounding and clamping, result register
   rek_back #(
      .PERIOD_MAX (PERIOD_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_bus    (csr_bus),
      .rsp_bus    (rsp_bus),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

endmodule

/* src/rek_front.sv */
// input intake and short item queue
module rek_front import rek_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   rek_req_if.sink  req_bus,
   output logic     item_valid,
   output item_type item,
   input  logic     item_pop
);

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   item_type         q_ff [QUEUE_DEPTH];
   logic [QAW-1:0]   wr_ff, wr_in;
   logic [QAW-1:0]   rd_ff, rd_in;
   logic [QCW-1:0]   cnt_ff, cnt_in;
   logic             push, pop;
   item_type         beat;

   assign req_bus.ready = (cnt_ff != QCW'(QUEUE_DEPTH));
   assign push          = req_bus.valid && req_bus.ready;
   assign item_valid    = (cnt_ff != '0);
   assign pop           = item_pop && item_valid;
   assign item          = q_ff[rd_ff];

   always_comb begin
      beat.sample     = req_bus.sample;
      beat.new_series = req_bus.new_series;
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= beat;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* src/rek_mul.sv */
// shared multi-cycle multiplier, 128-bit wrapping product, one byte of b per cycle
module rek_mul import rek_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [WIDE_W-1:0] op_a,
   input  logic signed [OPB_W-1:0]  op_b,
   output logic                     done,
   output logic signed [WIDE_W-1:0] prod
);

   logic [WIDE_W-1:0]         acc_ff, acc_in;
   logic [WIDE_W-1:0]         ash_ff, ash_in;
   logic [OPB_W-1:0]          brem_ff, brem_in;
   logic                      neg_ff, neg_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [WIDE_W+DIGIT_W-1:0] pp;

   assign pp   = ash_ff * brem_ff[DIGIT_W-1:0];
   assign done = done_ff;
   assign prod = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);

   always_comb begin
      acc_in  = acc_ff;
      ash_in  = ash_ff;
      brem_in = brem_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         ash_in  = op_a;
         brem_in = op_b[OPB_W-1] ? OPB_W'(-op_b) : OPB_W'(op_b);
         neg_in  = op_b[OPB_W-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (brem_ff != '0) begin
            acc_in  = acc_ff + pp[WIDE_W-1:0];
            ash_in  = ash_ff << DIGIT_W;
            brem_in = brem_ff >> DIGIT_W;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      ash_ff  <= ash_in;
      brem_ff <= brem_in;
      neg_ff  <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

/* src/rek_back.sv */
// window update, moment sums, kurtosis sequencer and divider
module rek_back import rek_pkg::*; #(
   parameter int PERIOD_MAX = PERIOD_MAX_DEF
) (
   input  logic     clock,
   input  logic     reset,
   rek_csr_if.sink  csr_bus,
   rek_rsp_if.source rsp_bus,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_pop
);

   localparam int AW   = (PERIOD_MAX > 1) ? $clog2(PERIOD_MAX) : 1;
   localparam int NW   = $clog2(PERIOD_MAX + 1);
   localparam int SQ_W = 2 * SAMPLE_W;
   localparam int CU_W = 3 * SAMPLE_W;
   localparam int QU_W = 4 * SAMPLE_W;
   localparam int DS_W = WIDE_W + KURT_W - 1;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_RD   = 5'd1;
   localparam logic [4:0] ST_OLDW = 5'd2;
   localparam logic [4:0] ST_P1   = 5'd3;
   localparam logic [4:0] ST_P2   = 5'd4;
   localparam logic [4:0] ST_P3   = 5'd5;
   localparam logic [4:0] ST_WR   = 5'd6;
   localparam logic [4:0] ST_M1   = 5'd7;
   localparam logic [4:0] ST_M2   = 5'd8;
   localparam logic [4:0] ST_CHK  = 5'd9;
   localparam logic [4:0] ST_M5   = 5'd10;
   localparam logic [4:0] ST_M6   = 5'd11;
   localparam logic [4:0] ST_M7   = 5'd12;
   localparam logic [4:0] ST_M8   = 5'd13;
   localparam logic [4:0] ST_M9   = 5'd14;
   localparam logic [4:0] ST_M10  = 5'd15;
   localparam logic [4:0] ST_M11  = 5'd16;
   localparam logic [4:0] ST_M12  = 5'd17;
   localparam logic [4:0] ST_M13  = 5'd18;
   localparam logic [4:0] ST_M14  = 5'd19;
   localparam logic [4:0] ST_DSET = 5'd20;
   localparam logic [4:0] ST_DRUN = 5'd21;
   localparam logic [4:0] ST_FIN  = 5'd22;
   localparam logic [4:0] ST_OUT  = 5'd23;

   logic [4:0]                 st_ff, st_in;
   logic [PERIOD_W-1:0]        period_ff, period_in;
   logic [NW-1:0]              fill_ff, fill_in;
   logic [AW-1:0]              wp_ff, wp_in;
   logic signed [S1_W-1:0]     s1_ff, s1_in;
   logic signed [S2_W-1:0]     s2_ff, s2_in;
   logic signed [S3_W-1:0]     s3_ff, s3_in;
   logic signed [S4_W-1:0]     s4_ff, s4_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [SAMPLE_W-1:0] px_ff, px_in;
   logic                       oldph_ff, oldph_in;
   logic signed [SQ_W-1:0]     sq_ff, sq_in;
   logic signed [CU_W-1:0]     cu_ff, cu_in;
   logic signed [QU_W-1:0]     qu_ff, qu_in;
   logic                       mrun_ff, mrun_in;
   logic signed [WIDE_W-1:0]   p_ff, p_in;
   logic signed [OPB_W-1:0]    s11_ff, s11_in;
   logic signed [OPB_W-1:0]    a_ff, a_in;
   logic signed [WIDE_W-1:0]   bacc_ff, bacc_in;
   logic signed [WIDE_W-1:0]   a2_ff, a2_in;
   logic signed [WIDE_W-1:0]   num_ff, num_in;
   logic signed [WIDE_W-1:0]   den_ff, den_in;
   logic                       neg_ff, neg_in;
   logic                       sat_ff, sat_in;
   logic [WIDE_W-1:0]          rem_ff, rem_in;
   logic [DS_W-1:0]            dsh_ff, dsh_in;
   logic [KURT_W-1:0]          q_ff, q_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic signed [KURT_W-1:0]   kurt_ff, kurt_in;
   logic                       undef_ff, undef_in;
   logic                       ov_ff, ov_in;
   logic signed [KURT_W-1:0]   ok_ff, ok_in;
   logic                       ou_ff, ou_in;

   logic [2*NW-1:0]            n2_ff;
   logic [3*NW-1:0]            n3_ff;
   logic [2*NW-1:0]            knm_ff;
   logic [2*NW+1:0]            k3_ff;
   logic [2*NW-1:0]            kd_ff;
   logic [NW-1:0]              n_eff, nm1, nm2, nm3;

   logic signed [SAMPLE_W-1:0] mem [PERIOD_MAX];
   logic signed [SAMPLE_W-1:0] rd_ff;
   logic                       mem_we, mem_re;
   logic [AW-1:0]              mem_ra;
   logic [NW-1:0]              wp_ext, old_full, fill_n;

   logic                       mul_start, mul_done, mul_state;
   logic signed [WIDE_W-1:0]   mul_a, mul_prod;
   logic signed [OPB_W-1:0]    mul_b;

   logic [WIDE_W-1:0]          mag, nq, d2;
   logic                       ge;

   rek_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign csr_bus.ready           = 1'b1;
   assign rsp_bus.valid           = ov_ff;
   assign rsp_bus.excess_kurtosis = ok_ff;
   assign rsp_bus.undefined       = ou_ff;
   assign item_pop                = (st_ff == ST_IDLE) && item_valid;

   // effective window length and its derived constants
   always_comb begin
      if (period_ff < PERIOD_W'(PERIOD_MIN)) begin
         n_eff = NW'(PERIOD_MIN);
      end else if ({1'b0, period_ff} > (PERIOD_W + 1)'(PERIOD_MAX)) begin
         n_eff = NW'(PERIOD_MAX);
      end else begin
         n_eff = NW'(period_ff);
      end
      nm1 = n_eff - NW'(1);
      nm2 = n_eff - NW'(2);
      nm3 = n_eff - NW'(3);
   end

   always_ff @(posedge clock) begin
      n2_ff  <= n_eff * n_eff;
      n3_ff  <= n2_ff * n_eff;
      knm_ff <= n2_ff - 1'b1;
      k3_ff  <= (2 * NW + 2)'(nm1 * nm1) * (2 * NW + 2)'(3);
      kd_ff  <= nm2 * nm3;
   end

   // window store
   assign wp_ext   = NW'(wp_ff);
   assign old_full = (wp_ext >= n_eff) ? wp_ext - n_eff
                                       : wp_ext + (NW'(PERIOD_MAX) - n_eff);
   assign mem_ra   = old_full[AW-1:0];
   assign mem_re   = (st_ff == ST_RD) && (fill_ff >= n_eff);
   assign mem_we   = (st_ff == ST_WR);
   assign fill_n   = (fill_ff < n_eff) ? fill_ff + 1'b1 : fill_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= x_ff;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   // multiplier operand selection
   always_comb begin
      mul_state = 1'b1;
      mul_a     = '0;
      mul_b     = '0;
      unique case (st_ff)
         ST_M1: begin
            mul_a = WIDE_W'(s2_ff);
            mul_b = OPB_W'(n_eff);
         end
         ST_M2: begin
            mul_a = WIDE_W'(s1_ff);
            mul_b = OPB_W'(s1_ff);
         end
         ST_M5: begin
            mul_a = WIDE_W'(s4_ff);
            mul_b = OPB_W'(n3_ff);
         end
         ST_M6: begin
            mul_a = WIDE_W'(s3_ff);
            mul_b = OPB_W'(s1_ff);
         end
         ST_M7: begin
            mul_a = p_ff;
            mul_b = OPB_W'(n2_ff);
         end
         ST_M8: begin
            mul_a = WIDE_W'(s11_ff);
            mul_b = OPB_W'(s2_ff);
         end
         ST_M9: begin
            mul_a = p_ff;
            mul_b = OPB_W'(n_eff);
         end
         ST_M10: begin
            mul_a = WIDE_W'(s11_ff);
            mul_b = s11_ff;
         end
         ST_M11: begin
            mul_a = WIDE_W'(a_ff);
            mul_b = a_ff;
         end
         ST_M12: begin
            mul_a = bacc_ff;
            mul_b = OPB_W'(knm_ff);
         end
         ST_M13: begin
            mul_a = a2_ff;
            mul_b = OPB_W'(k3_ff);
         end
         ST_M14: begin
            mul_a = a2_ff;
            mul_b = OPB_W'(kd_ff);
         end
         default: begin
            mul_state = 1'b0;
         end
      endcase
   end

   assign mul_start = mul_state && !mrun_ff;

   // divider setup terms
   always_comb begin
      mag = num_ff[WIDE_W-1] ? WIDE_W'(-num_ff) : WIDE_W'(num_ff);
      nq  = (mag << 17) + WIDE_W'(den_ff);
      d2  = WIDE_W'(den_ff) << 1;
      ge  = ({(DS_W - WIDE_W)'(0), rem_ff} >= dsh_ff);
   end

   always_comb begin
      st_in     = st_ff;
      period_in = period_ff;
      fill_in   = fill_ff;
      wp_in     = wp_ff;
      s1_in     = s1_ff;
      s2_in     = s2_ff;
      s3_in     = s3_ff;
      s4_in     = s4_ff;
      x_in      = x_ff;
      px_in     = px_ff;
      oldph_in  = oldph_ff;
      sq_in     = sq_ff;
      cu_in     = cu_ff;
      qu_in     = qu_ff;
      mrun_in   = mrun_ff;
      p_in      = p_ff;
      s11_in    = s11_ff;
      a_in      = a_ff;
      bacc_in   = bacc_ff;
      a2_in     = a2_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      sat_in    = sat_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      kurt_in   = kurt_ff;
      undef_in  = undef_ff;
      ov_in     = ov_ff && !rsp_bus.ready;
      ok_in     = ok_ff;
      ou_in     = ou_ff;

      if (mul_start) begin
         mrun_in = 1'b1;
      end else if (mul_done) begin
         mrun_in = 1'b0;
      end

      unique case (st_ff)
         ST_IDLE: begin
            if (item_valid) begin
               x_in = item.sample;
               if (item.new_series) begin
                  fill_in = '0;
                  wp_in   = '0;
                  s1_in   = '0;
                  s2_in   = '0;
                  s3_in   = '0;
                  s4_in   = '0;
               end
               st_in = ST_RD;
            end
         end
         ST_RD: begin
            if (fill_ff >= n_eff) begin
               st_in = ST_OLDW;
            end else begin
               px_in    = x_ff;
               oldph_in = 1'b0;
               st_in    = ST_P1;
            end
         end
         ST_OLDW: begin
            px_in    = rd_ff;
            oldph_in = 1'b1;
            st_in    = ST_P1;
         end
         ST_P1: begin
            sq_in = px_ff * px_ff;
            st_in = ST_P2;
         end
         ST_P2: begin
            cu_in = sq_ff * CU_W'(px_ff);
            qu_in = QU_W'(sq_ff) * QU_W'(sq_ff);
            st_in = ST_P3;
         end
         ST_P3: begin
            if (oldph_ff) begin
               s1_in    = s1_ff - S1_W'(px_ff);
               s2_in    = s2_ff - S2_W'(sq_ff);
               s3_in    = s3_ff - S3_W'(cu_ff);
               s4_in    = s4_ff - S4_W'(qu_ff);
               px_in    = x_ff;
               oldph_in = 1'b0;
               st_in    = ST_P1;
            end else begin
               s1_in = s1_ff + S1_W'(px_ff);
               s2_in = s2_ff + S2_W'(sq_ff);
               s3_in = s3_ff + S3_W'(cu_ff);
               s4_in = s4_ff + S4_W'(qu_ff);
               st_in = ST_WR;
            end
         end
         ST_WR: begin
            wp_in   = (wp_ff == AW'(PERIOD_MAX - 1)) ? '0 : wp_ff + 1'b1;
            fill_in = fill_n;
            st_in   = (fill_n < n_eff) ? ST_IDLE : ST_M1;
         end
         ST_M1: begin
            if (mul_done) begin
               p_in  = mul_prod;
               st_in = ST_M2;
            end
         end
         ST_M2: begin
            if (mul_done) begin
               s11_in = OPB_W'(mul_prod);
               a_in   = OPB_W'(p_ff) - OPB_W'(mul_prod);
               st_in  = ST_CHK;
            end
         end
         ST_CHK: begin
            if (a_ff <= 0) begin
               kurt_in  = '0;
               undef_in = 1'b1;
               st_in    = ST_OUT;
            end else begin
               st_in = ST_M5;
            end
         end
         ST_M5: begin
            if (mul_done) begin
               bacc_in = mul_prod;
               st_in   = ST_M6;
            end
         end
         ST_M6: begin
            if (mul_done) begin
               p_in  = mul_prod;
               st_in = ST_M7;
            end
         end
         ST_M7: begin
            if (mul_done) begin
               bacc_in = bacc_ff - (mul_prod <<< 2);
               st_in   = ST_M8;
            end
         end
         ST_M8: begin
            if (mul_done) begin
               p_in  = mul_prod;
               st_in = ST_M9;
            end
         end
         ST_M9: begin
            if (mul_done) begin
               bacc_in = bacc_ff + (mul_prod <<< 2) + (mul_prod <<< 1);
               st_in   = ST_M10;
            end
         end
         ST_M10: begin
            if (mul_done) begin
               bacc_in = bacc_ff - mul_prod - (mul_prod <<< 1);
               st_in   = ST_M11;
            end
         end
         ST_M11: begin
            if (mul_done) begin
               a2_in = mul_prod;
               st_in = ST_M12;
            end
         end
         ST_M12: begin
            if (mul_done) begin
               num_in = mul_prod;
               st_in  = ST_M13;
            end
         end
         ST_M13: begin
            if (mul_done) begin
               num_in = num_ff - mul_prod;
               st_in  = ST_M14;
            end
         end
         ST_M14: begin
            if (mul_done) begin
               den_in = mul_prod;
               st_in  = ST_DSET;
            end
         end
         ST_DSET: begin
            neg_in = num_ff[WIDE_W-1];
            sat_in = ({KURT_W'(0), nq} >= {d2, KURT_W'(0)});
            rem_in = nq;
            dsh_in = {d2, (KURT_W - 1)'(0)};
            q_in   = '0;
            cnt_in = 5'd31;
            st_in  = ({KURT_W'(0), nq} >= {d2, KURT_W'(0)}) ? ST_FIN : ST_DRUN;
         end
         ST_DRUN: begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff[WIDE_W-1:0];
            end
            q_in   = {q_ff[KURT_W-2:0], ge};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               st_in = ST_FIN;
            end
         end
         ST_FIN: begin
            undef_in = 1'b0;
            if (neg_ff) begin
               kurt_in = (sat_ff || q_ff[KURT_W-1]) ? {1'b1, (KURT_W - 1)'(0)}
                                                    : -$signed(q_ff);
            end else begin
               kurt_in = (sat_ff || q_ff[KURT_W-1]) ? {1'b0, {(KURT_W - 1){1'b1}}}
                                                    : $signed(q_ff);
            end
            st_in = ST_OUT;
         end
         ST_OUT: begin
            if (!ov_ff || rsp_bus.ready) begin
               ov_in = 1'b1;
               ok_in = kurt_ff;
               ou_in = undef_ff;
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      // a period write restarts the window
      if (csr_bus.valid) begin
         period_in = csr_bus.period;
         fill_in   = '0;
         wp_in     = '0;
         s1_in     = '0;
         s2_in     = '0;
         s3_in     = '0;
         s4_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      px_ff    <= px_in;
      oldph_ff <= oldph_in;
      sq_ff    <= sq_in;
      cu_ff    <= cu_in;
      qu_ff    <= qu_in;
      p_ff     <= p_in;
      s11_ff   <= s11_in;
      a_ff     <= a_in;
      bacc_ff  <= bacc_in;
      a2_ff    <= a2_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      sat_ff   <= sat_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      kurt_ff  <= kurt_in;
      undef_ff <= undef_in;
      ok_ff    <= ok_in;
      ou_ff    <= ou_in;
      if (reset) begin
         st_ff     <= ST_IDLE;
         period_ff <= PERIOD_RESET;
         fill_ff   <= '0;
         wp_ff     <= '0;
         s1_ff     <= '0;
         s2_ff     <= '0;
         s3_ff     <= '0;
         s4_ff     <= '0;
         mrun_ff   <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         st_ff     <= st_in;
         period_ff <= period_in;
         fill_ff   <= fill_in;
         wp_ff     <= wp_in;
         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         s3_ff     <= s3_in;
         s4_ff     <= s4_in;
         mrun_ff   <= mrun_in;
         ov_ff     <= ov_in;
      end
   end

endmodule
